/* hw/rtl/midpoint_line_rasterizer_core_defines.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication check on aclk, muted while aresetn is low.
`define MLR_ASSERT_IMPL(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rasterizer check failed");
// Condition that must never be true on a clock edge.
`define MLR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("rasterizer forbidden condition seen");
`else
`define MLR_ASSERT_IMPL(lbl, prop)
`define MLR_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* hw/rtl/mlr_pkg.sv */
// Types and constants of the midpoint line rasterizer.
`timescale 1ns / 1ps
package mlr_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 24;
    // decision variable and increments stay within four times the tile side
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } segment_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } pixel_t;

    typedef enum logic [1:0] {
        OCT_SHALLOW_RISE = 2'd0,
        OCT_STEEP_RISE   = 2'd1,
        OCT_SHALLOW_FALL = 2'd2,
        OCT_STEEP_FALL   = 2'd3
    } octant_t;

    typedef struct packed {
        logic load;
        logic init;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/midpoint_line_rasterizer_core.sv */
// Top level of the midpoint line rasterizer: sequencer, datapath and checks.
//
// Rasterizes one segment per input transaction inside a 64 by 64 tile and
// returns its pixels in walking order, one output transaction per pixel,
// each carrying the segment color, with last_pixel set on the final one.
// The walk always runs toward the larger major coordinate, so a segment may
// come out in the reverse of the order its endpoints were given. A segment
// with |major delta| = n yields n+1 pixels; equal endpoints yield a single
// pixel. A segment goes through setup (case select and swap, then decision
// variable and increments) and then yields one pixel per cycle when the
// output side does not stall. The pixel rate is set by the single midpoint
// step unit, which advances once per cycle into the output register while
// the output side does not stall. One segment is processed at a time; the
// next one is taken as soon as the final pixel sits in the output register,
// even if that pixel has not yet been consumed.
`timescale 1ns / 1ps
`include "midpoint_line_rasterizer_core_defines.svh"
module midpoint_line_rasterizer_core import mlr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    // segment input
    input  logic     s_valid,
    output logic     s_ready,
    input  segment_t s_data,
    // pixel output
    output logic     m_valid,
    input  logic     m_ready,
    output pixel_t   m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // control: idle / setup / walk sequencing
    mlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath: decision variable, walk position, output register
    mlr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // one segment in flight: ready drops right after a segment is taken
    `MLR_ASSERT_IMPL(a_one_segment, (s_valid && s_ready) |=> !s_ready)
    // a new segment is never taken while a non-final pixel is pending
    `MLR_ASSERT_NEVER(a_no_early_accept, s_ready && m_valid && !m_data.last_pixel)
    // after a non-final pixel is consumed the next one follows at once
    `MLR_ASSERT_IMPL(a_walk_continues,
        (m_valid && m_ready && !m_data.last_pixel) |=> m_valid)

endmodule

/* hw/rtl/mlr_ctrl.sv */
// Sequencer of the line rasterizer: setup, walk and hand-off control.
`timescale 1ns / 1ps
module mlr_ctrl import mlr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.steps_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

/* hw/rtl/mlr_datapath.sv */
// Datapath of the line rasterizer: case select, setup, midpoint step, output register.
`timescale 1ns / 1ps
module mlr_datapath import mlr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  segment_t   s_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output pixel_t     m_data
);

    function automatic dec_t widen(coord_t v);
        return dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, v});
    endfunction

    // endpoints after swap, held from load to init
    coord_t  pa_x_reg, pa_y_reg, pb_x_reg, pb_y_reg;
    octant_t oct_reg, oct_next;
    color_t  color_reg;

    // walk state
    coord_t  walk_x_reg, walk_y_reg, walk_x_next, walk_y_next;
    dec_t    dec_reg, dec_next;
    dec_t    inc_a_reg, inc_b_reg;
    coord_t  steps_reg;

    pixel_t  out_reg;
    logic    out_valid_reg;

    // case selection on the incoming segment
    logic signed [COORD_BITS:0] dx, dy, adx, ady;
    logic shallow, same_sign, opposite, swap;

    always_comb begin
        dx        = $signed({1'b0, s_data.end_x}) - $signed({1'b0, s_data.start_x});
        dy        = $signed({1'b0, s_data.end_y}) - $signed({1'b0, s_data.start_y});
        adx       = dx[COORD_BITS] ? -dx : dx;
        ady       = dy[COORD_BITS] ? -dy : dy;
        shallow   = (ady <= adx);
        same_sign = (dx > 0 && dy >= 0) || (dx < 0 && dy <= 0);
        opposite  = (dx > 0 && dy < 0) || (dx < 0 && dy > 0);
        priority if (shallow && dx != 0 && same_sign) begin
            oct_next = OCT_SHALLOW_RISE;
        end else if (!shallow && ((dx == 0 && dy > 0) || same_sign)) begin
            oct_next = OCT_STEEP_RISE;
        end else if (shallow && opposite) begin
            oct_next = OCT_SHALLOW_FALL;
        end else begin
            oct_next = OCT_STEEP_FALL;
        end
        if (oct_next == OCT_SHALLOW_RISE || oct_next == OCT_SHALLOW_FALL) begin
            swap = (s_data.start_x > s_data.end_x);
        end else begin
            swap = (s_data.start_y > s_data.end_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pa_x_reg  <= swap ? s_data.end_x   : s_data.start_x;
            pa_y_reg  <= swap ? s_data.end_y   : s_data.start_y;
            pb_x_reg  <= swap ? s_data.start_x : s_data.end_x;
            pb_y_reg  <= swap ? s_data.start_y : s_data.end_y;
            oct_reg   <= oct_next;
            color_reg <= s_data.line_color;
        end
    end

    // setup of decision variable and increments
    dec_t mx, my, init_dec, init_a, init_b;
    coord_t init_steps;

    always_comb begin
        mx = widen(pb_x_reg) - widen(pa_x_reg);
        my = widen(pb_y_reg) - widen(pa_y_reg);
        unique case (oct_reg)
            OCT_SHALLOW_RISE: begin
                init_dec   = mx - (my <<< 1);
                init_a     = (mx <<< 1) - (my <<< 1);
                init_b     = -(my <<< 1);
                init_steps = mx[COORD_BITS-1:0];
            end
            OCT_STEEP_RISE: begin
                init_dec   = (mx <<< 1) - my;
                init_a     = mx <<< 1;
                init_b     = (mx - my) <<< 1;
                init_steps = my[COORD_BITS-1:0];
            end
            OCT_SHALLOW_FALL: begin
                init_dec   = -mx - (my <<< 1);
                init_a     = -(my <<< 1);
                init_b     = -((mx + my) <<< 1);
                init_steps = mx[COORD_BITS-1:0];
            end
            default: begin
                init_dec   = (mx <<< 1) + my;
                init_a     = mx <<< 1;
                init_b     = (mx + my) <<< 1;
                init_steps = my[COORD_BITS-1:0];
            end
        endcase
    end

    // one midpoint step
    logic take_a;

    always_comb begin
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        unique case (oct_reg)
            OCT_SHALLOW_RISE: begin
                take_a      = (dec_reg <= 0);
                walk_x_next = walk_x_reg + 1'b1;
                if (take_a) walk_y_next = walk_y_reg + 1'b1;
            end
            OCT_STEEP_RISE: begin
                take_a      = (dec_reg < 0);
                walk_y_next = walk_y_reg + 1'b1;
                if (!take_a) walk_x_next = walk_x_reg + 1'b1;
            end
            OCT_SHALLOW_FALL: begin
                take_a      = (dec_reg < 0);
                walk_x_next = walk_x_reg + 1'b1;
                if (!take_a) walk_y_next = walk_y_reg - 1'b1;
            end
            default: begin
                take_a      = (dec_reg > 0);
                walk_y_next = walk_y_reg + 1'b1;
                if (!take_a) walk_x_next = walk_x_reg - 1'b1;
            end
        endcase
        dec_next = dec_reg + (take_a ? inc_a_reg : inc_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            walk_x_reg <= pa_x_reg;
            walk_y_reg <= pa_y_reg;
            dec_reg    <= init_dec;
            inc_a_reg  <= init_a;
            inc_b_reg  <= init_b;
            steps_reg  <= init_steps;
        end else if (cmd.emit && steps_reg != '0) begin
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            dec_reg    <= dec_next;
            steps_reg  <= steps_reg - 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.pixel_x     <= walk_x_reg;
            out_reg.pixel_y     <= walk_y_reg;
            out_reg.pixel_color <= color_reg;
            out_reg.last_pixel  <= (steps_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free   = !out_valid_reg || m_ready;
    assign status.steps_zero = (steps_reg == '0);
    assign m_valid           = out_valid_reg;
    assign m_data            = out_reg;

endmodule

/* bench/midpoint_line_rasterizer_core_tb.sv */
// Self-checking testbench for the midpoint line rasterizer core.
`timescale 1ns / 1ps
module midpoint_line_rasterizer_core_tb;
    import mlr_pkg::*;

    localparam int CYCLE_LIMIT    = 800000;
    localparam int DRAIN_CYCLES   = 70;   // longest segment plus setup
    localparam int ITEMS_PER_PASS = 115;

    // Keeps the pixels still owed by the core and checks each one as it leaves.
    class line_pixel_checker;
        pixel_t owed_pixels[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Walks the segment the way the core should and queues every pixel.
        function void note_segment(segment_t seg);
            int      ax, ay, bx, by, dx, dy, t, mx, my;
            int      d, inc_a, inc_b, steps;
            bit      shallow, same_sign, opposite;
            octant_t oct;
            coord_t  wx, wy;
            pixel_t  px;
            ax = seg.start_x;
            ay = seg.start_y;
            bx = seg.end_x;
            by = seg.end_y;
            dx = bx - ax;
            dy = by - ay;
            shallow   = ((dy < 0) ? -dy : dy) <= ((dx < 0) ? -dx : dx);
            same_sign = (dx > 0 && dy >= 0) || (dx < 0 && dy <= 0);
            opposite  = (dx > 0 && dy < 0) || (dx < 0 && dy > 0);

            if (shallow && dx != 0 && same_sign)
                oct = OCT_SHALLOW_RISE;
            else if (!shallow && ((dx == 0 && dy > 0) || same_sign))
                oct = OCT_STEEP_RISE;
            else if (shallow && opposite)
                oct = OCT_SHALLOW_FALL;
            else
                oct = OCT_STEEP_FALL;   // also zero length and vertical down

            // walk toward the larger major coordinate
            if ((oct == OCT_SHALLOW_RISE || oct == OCT_SHALLOW_FALL) ? (ax > bx) : (ay > by)) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            mx = bx - ax;
            my = by - ay;

            case (oct)
                OCT_SHALLOW_RISE: begin
                    d = mx - 2 * my; inc_a = 2 * mx - 2 * my; inc_b = -2 * my; steps = mx;
                end
                OCT_STEEP_RISE: begin
                    d = 2 * mx - my; inc_a = 2 * mx; inc_b = 2 * (mx - my); steps = my;
                end
                OCT_SHALLOW_FALL: begin
                    d = -mx - 2 * my; inc_a = -2 * my; inc_b = -2 * (mx + my); steps = mx;
                end
                default: begin
                    d = 2 * mx + my; inc_a = 2 * mx; inc_b = 2 * (mx + my); steps = my;
                end
            endcase

            wx = coord_t'(ax);
            wy = coord_t'(ay);
            px.pixel_color = seg.line_color;
            px.pixel_x     = wx;
            px.pixel_y     = wy;
            px.last_pixel  = (steps == 0);
            owed_pixels.push_back(px);

            while (steps > 0) begin
                case (oct)
                    OCT_SHALLOW_RISE: begin
                        if (d <= 0) begin
                            wy++;
                            d += inc_a;
                        end else begin
                            d += inc_b;
                        end
                        wx++;
                    end
                    OCT_STEEP_RISE: begin
                        if (d < 0) begin
                            d += inc_a;
                        end else begin
                            wx++;
                            d += inc_b;
                        end
                        wy++;
                    end
                    OCT_SHALLOW_FALL: begin
                        if (d < 0) begin
                            d += inc_a;
                        end else begin
                            wy--;
                            d += inc_b;
                        end
                        wx++;
                    end
                    default: begin
                        if (d > 0) begin
                            d += inc_a;
                        end else begin
                            wx--;
                            d += inc_b;
                        end
                        wy++;
                    end
                endcase
                steps--;
                px.pixel_x    = wx;
                px.pixel_y    = wy;
                px.last_pixel = (steps == 0);
                owed_pixels.push_back(px);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (owed_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
                mismatches++;
                return;
            end
            want = owed_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x) begin
                $error("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x);
                mismatches++;
            end
            if (got.pixel_y !== want.pixel_y) begin
                $error("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y);
                mismatches++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $error("pixel_color expected %h got %h", want.pixel_color, got.pixel_color);
                mismatches++;
            end
            if (got.last_pixel !== want.last_pixel) begin
                $error("last_pixel expected %0b got %0b", want.last_pixel, got.last_pixel);
                mismatches++;
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    segment_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pixel_t   m_data;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;

    line_pixel_checker pixels = new();

    midpoint_line_rasterizer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL midpoint_line_rasterizer_core");
            $finish;
        end
    end

    // output side: random back-pressure, checked at the rising edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pixels.check_pixel(m_data);
    end

    function automatic segment_t make_segment(int ax, int ay, int bx, int by, color_t c);
        segment_t seg;
        seg.start_x    = coord_t'(ax);
        seg.start_y    = coord_t'(ay);
        seg.end_x      = coord_t'(bx);
        seg.end_y      = coord_t'(by);
        seg.line_color = c;
        return seg;
    endfunction

    // Valid stays up between back-to-back segments; it only drops on an idle gap.
    task automatic send_segment(segment_t seg);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= seg;
        do @(posedge aclk); while (!s_ready);
        pixels.note_segment(seg);
    endtask

    task automatic send_random_segments(int count);
        segment_t seg;
        for (int i = 0; i < count; i++) begin
            seg.start_x    = coord_t'($urandom);
            seg.start_y    = coord_t'($urandom);
            seg.line_color = color_t'($urandom);
            case ($urandom_range(9))
                0, 1, 2: begin
                    // short segment near the start point, may wrap the tile
                    seg.end_x = coord_t'(seg.start_x + $urandom_range(8) - 4);
                    seg.end_y = coord_t'(seg.start_y + $urandom_range(8) - 4);
                end
                3: begin
                    // diagonal unless end_y wraps the tile, the shallow/steep tie
                    seg.end_x = coord_t'($urandom);
                    seg.end_y = seg.start_y + ((seg.end_x >= seg.start_x) ?
                                (seg.end_x - seg.start_x) : (seg.start_x - seg.end_x));
                end
                4: begin
                    // axis aligned
                    seg.end_x = $urandom_range(1) ? seg.start_x : coord_t'($urandom);
                    seg.end_y = (seg.end_x == seg.start_x) ? coord_t'($urandom) : seg.start_y;
                end
                default: begin
                    seg.end_x = coord_t'($urandom);
                    seg.end_y = coord_t'($urandom);
                end
            endcase
            send_segment(seg);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed segments: extremes, every slope case, swaps and tie-breaks
        send_segment(make_segment(0, 0, 0, 0, 24'h000000));
        send_segment(make_segment(63, 63, 63, 63, 24'hFFFFFF));
        send_segment(make_segment(0, 0, 63, 0, 24'hAAAAAA));
        send_segment(make_segment(63, 5, 0, 5, 24'h555555));
        send_segment(make_segment(10, 0, 10, 63, 24'hFFFFFF));
        send_segment(make_segment(10, 63, 10, 0, 24'h000000));
        send_segment(make_segment(0, 0, 63, 63, 24'h123456));
        send_segment(make_segment(63, 63, 0, 0, 24'hFEDCBA));
        send_segment(make_segment(0, 63, 63, 0, 24'hAAAAAA));
        send_segment(make_segment(63, 0, 0, 63, 24'h555555));
        send_segment(make_segment(3, 4, 50, 20, 24'hFF0000));
        send_segment(make_segment(50, 20, 3, 4, 24'h00FF00));
        send_segment(make_segment(5, 2, 20, 60, 24'h0000FF));
        send_segment(make_segment(20, 60, 5, 2, 24'hFFFFFF));
        send_segment(make_segment(2, 40, 60, 30, 24'h000000));
        send_segment(make_segment(60, 30, 2, 40, 24'h800001));
        send_segment(make_segment(30, 1, 22, 62, 24'h7FFFFE));
        send_segment(make_segment(22, 62, 30, 1, 24'hC3C3C3));
        send_segment(make_segment(0, 0, 2, 1, 24'h3C3C3C));
        send_segment(make_segment(0, 0, 1, 2, 24'h0F0F0F));
        send_segment(make_segment(0, 1, 2, 0, 24'hF0F0F0));
        send_segment(make_segment(1, 0, 0, 2, 24'h010101));
        send_segment(make_segment(0, 0, 1, 0, 24'hFEFEFE));
        send_segment(make_segment(0, 0, 0, 1, 24'h999999));
        send_segment(make_segment(62, 63, 63, 63, 24'h666666));

        // random passes: no pressure, sender gaps, receiver stalls, then both
        send_random_segments(ITEMS_PER_PASS);
        sender_idle_pct = 67;
        send_random_segments(ITEMS_PER_PASS);
        sender_idle_pct = 0;
        receiver_stall_pct = 67;
        send_random_segments(ITEMS_PER_PASS);
        sender_idle_pct = 21;
        receiver_stall_pct = 21;
        send_random_segments(ITEMS_PER_PASS);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixels.owed_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pixels.mismatches == 0) begin
            $display("PASS midpoint_line_rasterizer_core");
        end else begin
            $display("FAIL midpoint_line_rasterizer_core");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_ctrl.sv
hw/rtl/mlr_datapath.sv
hw/rtl/midpoint_line_rasterizer_core.sv
bench/midpoint_line_rasterizer_core_tb.sv
